// ===== rtl/relaxed_jacobi_pressure_update_unit_macros.svh =====
// Assertion macros shared by the pressure update RTL.
`ifndef RELAXED_JACOBI_PRESSURE_UPDATE_UNIT_MACROS_SVH
`define RELAXED_JACOBI_PRESSURE_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RJPU_CHECK(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RJPU_CHECK_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rjpu_pkg.sv =====
// Shared widths, codes and types of the relaxed Jacobi pressure update unit.
`default_nettype none

package rjpu_pkg;

  localparam int DATA_W    = 32;  // signed Q16.16 inputs
  localparam int Q_W       = 31;  // non-negative Q16.16 results
  localparam int OMEGA_W   = 16;  // unsigned Q1.15 relaxation weight
  localparam int CFG_W     = 31;  // widest register
  localparam int ADDR_W    = 2;
  localparam int SUM_W     = 64;  // milli error accumulator
  localparam int MILLI_W   = 25;  // floor(err * 1000 / 2^16)
  localparam int DENOM_W   = 42;  // 1000 * tally, tally up to 2^32
  localparam int DIV_REM_W = 42;  // widest divisor
  localparam int DIV_Q_W   = 32;  // quotient bits per division
  localparam int DIV_CNT_W = 6;

  localparam int MILLI_SCALE = 1000;

  localparam logic [OMEGA_W-1:0] RELAX_WEIGHT_RST = 16'd16384;
  localparam logic [CFG_W-1:0]   REST_DENSITY_RST = 31'd65536000;

  localparam logic [ADDR_W-1:0] REG_RELAX_WEIGHT = 2'd0;
  localparam logic [ADDR_W-1:0] REG_REST_DENSITY = 2'd1;

  localparam logic [1:0] STAT_UPDATED    = 2'd0;
  localparam logic [1:0] STAT_ALPHA_ZERO = 2'd1;
  localparam logic [1:0] STAT_RANGE      = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rjpu_div.sv =====
// Restoring divider: one quotient bit per cycle through a shift register.
`default_nettype none

module rjpu_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rjpu_pkg::DIV_REM_W-1:0] rem_init,
  input  logic [rjpu_pkg::DIV_Q_W-1:0]   lo_init,
  input  logic [rjpu_pkg::DIV_REM_W-1:0] divisor,
  output logic [rjpu_pkg::DIV_Q_W-1:0]   quo,
  output rjpu_pkg::div_stat_t            stat
);
  import rjpu_pkg::*;

  logic [DIV_REM_W-1:0] rem;
  logic [DIV_Q_W-1:0]   lo;
  logic [DIV_REM_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;

  logic [DIV_REM_W:0]   trial;
  logic [DIV_REM_W:0]   trial_sub;
  logic                 fits;
  logic [DIV_REM_W-1:0] rem_next;

  // rem < dvs holds between steps, so the shifted trial fits one extra bit
  assign trial     = {rem, lo[DIV_Q_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = !trial_sub[DIV_REM_W];
  assign rem_next  = fits ? trial_sub[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_Q_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - DIV_CNT_W'(1);
        done <= (cnt == DIV_CNT_W'(1));
      end
    end
  end

  // dividend low bits shift out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      lo  <= lo_init;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      lo  <= {lo[DIV_Q_W-2:0], fits};
    end
  end

  assign quo       = lo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== rtl/relaxed_jacobi_pressure_update_unit.sv =====
// Relaxed Jacobi pressure update top level: control sequencer and sweep statistics.
// Zero alpha or an early out-of-range quotient skips the quotient division; these, a late one, or
// a zero or saturated error skip the error division. The mean is divided only at sweep end, unless
// saturated. One particle at a time; the shared bit-serial divider is used up to 3 times.
// Synchronous reset clears the sequencer, statistics and output valid, and loads register defaults.
`default_nettype none
`include "relaxed_jacobi_pressure_update_unit_macros.svh"

module relaxed_jacobi_pressure_update_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rjpu_pkg::ADDR_W-1:0]         cfg_addr,
  input  logic [rjpu_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rjpu_pkg::DATA_W-1:0]  diag_coeff,
  input  logic signed [rjpu_pkg::DATA_W-1:0]  prev_pressure,
  input  logic signed [rjpu_pkg::DATA_W-1:0]  predicted_density,
  input  logic signed [rjpu_pkg::DATA_W-1:0]  neighbor_term,
  input  logic                                final_particle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rjpu_pkg::Q_W-1:0]            updated_pressure,
  output logic [1:0]                          update_status,
  output logic                                sweep_done,
  output logic [rjpu_pkg::Q_W-1:0]            mean_error,
  output logic [rjpu_pkg::Q_W-1:0]            peak_error
);
  import rjpu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_QCHK  = 4'd2;
  localparam logic [3:0] S_QDIV  = 4'd3;
  localparam logic [3:0] S_QFIX  = 4'd4;
  localparam logic [3:0] S_ECHK  = 4'd5;
  localparam logic [3:0] S_EDIV  = 4'd6;
  localparam logic [3:0] S_RELAX = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_MCHK  = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

  function automatic logic [Q_W-1:0] clamp31(input logic signed [35:0] v);
    logic [Q_W-1:0] r;
    if (v < 36'sd0) begin
      r = '0;
    end else if (v > 36'sh0_7FFF_FFFF) begin
      r = Q_MAX;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // registers
  logic [OMEGA_W-1:0]       relax_weight;
  logic [CFG_W-1:0]         rest_density;
  logic [3:0]               state;
  logic [DATA_W-1:0]        tally;
  logic [SUM_W-1:0]         err_sum;
  logic [Q_W-1:0]           err_peak;

  logic signed [DATA_W-1:0] alpha;
  logic signed [DATA_W-1:0] old;
  logic signed [DATA_W-1:0] rho;
  logic signed [DATA_W-1:0] beta;
  logic                     last_r;
  logic [CFG_W-1:0]         target;
  logic signed [33:0]       numer;
  logic signed [63:0]       prod;
  logic signed [63:0]       err_num;
  logic signed [32:0]       diff;
  logic signed [49:0]       scaled;
  logic [Q_W-1:0]           err;
  logic [MILLI_W-1:0]       milli;
  logic [Q_W-1:0]           pres;
  logic [1:0]               stat_code;
  logic [DENOM_W-1:0]       denom;
  logic [Q_W-1:0]           mean;

  // combinational
  logic                     accept;
  logic                     out_load;
  logic signed [33:0]       numer_next;
  logic signed [63:0]       prod_next;
  logic [33:0]              numer_abs;
  logic [32:0]              nmag;
  logic [DATA_W-1:0]        amag;
  logic                     q_ovf_pre;
  logic                     q_neg;
  logic                     q_ovf;
  logic signed [DATA_W-1:0] q_val;
  logic signed [32:0]       diff_next;
  logic signed [63:0]       err_num_next;
  logic                     err_pos;
  logic                     err_sat;
  logic signed [49:0]       scaled_adj;
  logic signed [34:0]       delta;
  logic [Q_W-1:0]           pres_relax;
  logic [Q_W-1:0]           pres_keep;
  logic [40:0]              err_milli;
  logic [32:0]              count;
  logic [DENOM_W-1:0]       denom_next;
  logic                     mean_sat;

  logic                     div_start;
  logic [DIV_REM_W-1:0]     div_rem_init;
  logic [DIV_Q_W-1:0]       div_lo_init;
  logic [DIV_REM_W-1:0]     div_divisor;
  logic [DIV_Q_W-1:0]       div_quo;
  div_stat_t                div_st;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign numer_next = $signed({3'b000, target})
                    - $signed({{2{rho[DATA_W-1]}}, rho})
                    - $signed({{2{beta[DATA_W-1]}}, beta});
  assign prod_next  = 64'(alpha) * 64'(old);

  assign numer_abs = numer[33] ? 34'(-numer) : 34'(numer);
  assign nmag      = numer_abs[32:0];
  assign amag      = alpha[DATA_W-1] ? DATA_W'(-alpha) : DATA_W'(alpha);
  // |q| >= 2^32 when |numer| >= |alpha| * 2^16
  assign q_ovf_pre = {15'b0, nmag} >= {amag, 16'h0000};

  assign q_neg = numer[33] ^ alpha[DATA_W-1];
  assign q_ovf = q_neg ? (div_quo > 32'h8000_0000) : div_quo[DIV_Q_W-1];
  assign q_val = q_neg ? $signed(-div_quo) : $signed(div_quo);

  assign diff_next    = $signed({q_val[DATA_W-1], q_val}) - $signed({old[DATA_W-1], old});
  assign err_num_next = prod - $signed({{14{numer[33]}}, numer, 16'h0000});

  assign err_pos = !err_num[63] && (err_num != 64'sd0);
  assign err_sat = $unsigned(err_num) >= {2'b00, target, 31'h0};

  // truncate toward zero on the Q1.15 scaling
  assign scaled_adj = scaled[49] ? (scaled + 50'sd32767) : scaled;
  assign delta      = 35'(scaled_adj >>> 15);
  assign pres_relax = clamp31(36'(old) + 36'(delta));
  assign pres_keep  = clamp31(36'(old));

  assign err_milli = 41'(err) * 41'(MILLI_SCALE);

  // a wrapped tally stands for 2^32 particles
  assign count      = (tally == '0) ? {1'b1, 32'h0} : {1'b0, tally};
  assign denom_next = DENOM_W'(count) * DENOM_W'(MILLI_SCALE);
  assign mean_sat   = err_sum >= SUM_W'({denom, 15'h0});

  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_lo_init  = '0;
    div_divisor  = '0;
    unique case (state)
      S_QCHK: begin
        div_start    = (alpha != '0) && !q_ovf_pre;
        div_rem_init = DIV_REM_W'(nmag[32:16]);
        div_lo_init  = {nmag[15:0], 16'h0000};
        div_divisor  = DIV_REM_W'(amag);
      end
      S_ECHK: begin
        div_start    = err_pos && !err_sat;
        div_rem_init = DIV_REM_W'(err_num[62:32]);
        div_lo_init  = err_num[31:0];
        div_divisor  = DIV_REM_W'(target);
      end
      S_MCHK: begin
        div_start    = !mean_sat;
        div_rem_init = DIV_REM_W'(err_sum[63:16]);
        div_lo_init  = {err_sum[15:0], 16'h0000};
        div_divisor  = denom;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rjpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .lo_init  (div_lo_init),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .stat     (div_st)
  );

  // control and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_weight <= RELAX_WEIGHT_RST;
      rest_density <= REST_DENSITY_RST;
      state        <= S_IDLE;
      tally        <= '0;
      err_sum      <= '0;
      err_peak     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_RELAX_WEIGHT: relax_weight <= cfg_wr_data[OMEGA_W-1:0];
          REG_REST_DENSITY: rest_density <= cfg_wr_data;
          default: ;
        endcase
      end

      out_valid <= out_load ? 1'b1 : (out_valid && out_stall);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tally <= tally + DATA_W'(1);
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_QCHK;
        S_QCHK: begin
          if (alpha == '0 || q_ovf_pre) begin
            state <= S_FIN;
          end else begin
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_st.done) begin
            state <= S_QFIX;
          end
        end
        S_QFIX: state <= q_ovf ? S_FIN : S_ECHK;
        S_ECHK: state <= (err_pos && !err_sat) ? S_EDIV : S_RELAX;
        S_EDIV: begin
          if (div_st.done) begin
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (err > err_peak) begin
            err_peak <= err;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          err_sum <= err_sum + SUM_W'(milli);
          state   <= S_FIN;
        end
        S_FIN:  state <= last_r ? S_MCHK : S_DONE;
        S_MCHK: state <= mean_sat ? S_DONE : S_MDIV;
        S_MDIV: begin
          if (div_st.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            if (last_r) begin
              tally    <= '0;
              err_sum  <= '0;
              err_peak <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          alpha  <= diag_coeff;
          old    <= prev_pressure;
          rho    <= predicted_density;
          beta   <= neighbor_term;
          last_r <= final_particle;
          target <= (rest_density == '0) ? CFG_W'(1) : rest_density;
        end
      end
      S_PREP: begin
        numer <= numer_next;
        prod  <= prod_next;
      end
      S_QCHK: begin
        pres <= pres_keep;
        if (alpha == '0) begin
          stat_code <= STAT_ALPHA_ZERO;
        end else if (q_ovf_pre) begin
          stat_code <= STAT_RANGE;
        end
      end
      S_QFIX: begin
        diff    <= diff_next;
        err_num <= err_num_next;
        if (q_ovf) begin
          stat_code <= STAT_RANGE;
        end
      end
      S_ECHK: begin
        scaled <= 50'(diff) * 50'($signed({1'b0, relax_weight}));
        if (!err_pos) begin
          err <= '0;
        end else if (err_sat) begin
          err <= Q_MAX;
        end
      end
      S_EDIV: begin
        if (div_st.done) begin
          err <= div_quo[Q_W-1:0];
        end
      end
      S_RELAX: begin
        milli     <= err_milli[40:16];
        pres      <= pres_relax;
        stat_code <= STAT_UPDATED;
      end
      S_FIN: begin
        denom <= denom_next;
      end
      S_MCHK: begin
        if (mean_sat) begin
          mean <= Q_MAX;
        end
      end
      S_MDIV: begin
        if (div_st.done) begin
          mean <= div_quo[Q_W-1:0];
        end
      end
      S_DONE: begin
        if (out_load) begin
          updated_pressure <= pres;
          update_status    <= stat_code;
          sweep_done       <= last_r;
          mean_error       <= last_r ? mean : '0;
          peak_error       <= last_r ? err_peak : '0;
        end
      end
      default: ;
    endcase
  end

  `RJPU_CHECK(a_div_start_free, clk, rst, div_start, !div_st.busy, "divider restarted while busy")
  `RJPU_CHECK(a_div_busy_state, clk, rst, div_st.busy, (state == S_QDIV || state == S_EDIV || state == S_MDIV), "divider busy outside a divide state")
  `RJPU_CHECK(a_stats_mid_sweep, clk, rst, out_valid && !sweep_done, (mean_error == '0 && peak_error == '0), "statistics shown before sweep end")
  `RJPU_CHECK_NEXT(a_sweep_clear, clk, rst, out_load && last_r, (tally == '0 && err_sum == '0 && err_peak == '0), "sweep statistics not cleared")

endmodule

`default_nettype wire
